// ===== rtl/matrix_multiply_engine_defines.svh =====
// assertion macros for the matrix multiply engine
`ifndef MATRIX_MULTIPLY_ENGINE_DEFINES_SVH
`define MATRIX_MULTIPLY_ENGINE_DEFINES_SVH

// same-cycle implication, reset masks the check
`define MME_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define MME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mme_pkg.sv =====
// shared types, constants and helpers of the matrix multiply engine
package mme_pkg;

	localparam int MAX_DIM_DEF   = 8;
	localparam int ELEM_BITS_DEF = 16;
	localparam int REG_BITS      = 4;
	localparam int CFG_IDX_BITS  = 2;
	localparam int IDX_BITS      = 3;
	localparam int VALUE_BITS    = 36;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_ROWS_A     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_COLS_B     = 2'd2;

	// per-operation tag that rides along the mac pipeline
	typedef struct packed {
		logic                first;
		logic                last_t;
		logic [IDX_BITS-1:0] row;
		logic [IDX_BITS-1:0] col;
		logic                last;
	} tag_t;

	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// zero reads as one, anything above the maximum reads as the maximum
	function automatic logic [REG_BITS-1:0] eff_dim(input logic [REG_BITS-1:0] v,
			input int max_dim);
		logic [REG_BITS-1:0] r;
		if (v == '0) begin
			r = REG_BITS'(1);
		end else if (int'(v) > max_dim) begin
			r = REG_BITS'(max_dim);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== rtl/mme_ram.sv =====
// generic single-write, single-read ram with registered read data
module mme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [mme_pkg::addr_bits(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [mme_pkg::addr_bits(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);
	import mme_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/mme_mac.sv =====
// shared multiply-accumulate unit: registered product, then running sum
module mme_mac #(
	parameter int ELEM_BITS = mme_pkg::ELEM_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           valid_s1,
	input  mme_pkg::tag_t                  tag_s1,
	input  logic [ELEM_BITS-1:0]           a_s1,
	input  logic [ELEM_BITS-1:0]           b_s1,
	output logic                           res_valid,
	output mme_pkg::tag_t                  res_tag,
	output logic [mme_pkg::VALUE_BITS-1:0] res_sum
);
	import mme_pkg::*;

	localparam int PW = 2 * ELEM_BITS;
	localparam int XW = (PW > VALUE_BITS) ? PW : VALUE_BITS;

	logic signed [PW-1:0]   prod_s2;
	tag_t                   tag_s2;
	logic                   valid_s2;
	logic [VALUE_BITS-1:0]  acc_q;
	logic signed [XW-1:0]   prod_x;
	logic [VALUE_BITS-1:0]  sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= $signed(a_s1) * $signed(b_s1);
			tag_s2  <= tag_s1;
		end
		if (adv && valid_s2) begin
			acc_q <= sum;
		end
	end

	// sum wraps at the output width
	assign prod_x = XW'(prod_s2);
	assign sum    = (tag_s2.first ? '0 : acc_q) + VALUE_BITS'(prod_x);

	assign res_valid = valid_s2 && tag_s2.last_t;
	assign res_tag   = tag_s2;
	assign res_sum   = sum;

endmodule

// ===== rtl/matrix_multiply_engine.sv =====
// top level of the matrix multiply engine: loading, sequencer and result register
//
// Elements of A (rows_a x inner_size) and B (inner_size x cols_b) are loaded
// one beat per cycle in row-major order, op selecting the matrix. The beat that
// completes B starts the product: in_stall then stays high while a sequencer
// walks every (row, col, inner) triple through one shared multiply-accumulate
// unit, one multiply per cycle unless the output stalls, limited by the single
// read port of each store. The product therefore issues rows_a * cols_b *
// inner_size multiplies, each issue ending with its store read, then passes
// the pipeline (multiply, then accumulate into the output register) before
// the final result shows.
// Results leave in row-major order through an output register, out_last marks
// the final one. A stalled output freezes the issue and the pipeline. Loading
// of the next pair reopens right after the last issue, while trailing results
// still drain. A register write restarts loading of both matrices and should
// be done only while the block is idle. Extra A beats beyond rows_a*inner_size
// are dropped; a register value of zero acts as one, above MAX_DIM as MAX_DIM.
module matrix_multiply_engine #(
	parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
	parameter int ELEM_BITS = mme_pkg::ELEM_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write port
	input  logic                             cfg_we,
	input  logic [mme_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [mme_pkg::REG_BITS-1:0]     cfg_data,
	// element input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             op,
	input  logic [ELEM_BITS-1:0]             elem_value,
	// result output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [mme_pkg::IDX_BITS-1:0]     out_row,
	output logic [mme_pkg::IDX_BITS-1:0]     out_col,
	output logic [mme_pkg::VALUE_BITS-1:0]   out_value,
	output logic                             out_last
);
	import mme_pkg::*;

	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
	localparam int ADDR_W      = addr_bits(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	// one-hot sequencer states
	typedef enum logic [1:0] {
		ST_LOAD = 2'b01,
		ST_CALC = 2'b10
	} state_t;

	state_t state_q;

	// effective dimensions, already clamped
	logic [REG_BITS-1:0] m_q, k_q, n_q;
	logic [CNT_W-1:0]    a_count_q, b_count_q;
	logic [CNT_W-1:0]    a_size, b_size, b_cnt_nx;

	logic in_acc, a_wr, b_wr, b_done, cfg_hit;

	// issue counters
	logic [IDX_BITS-1:0] i_q, j_q, t_q;
	logic [ADDR_W-1:0]   a_base_q, b_addr_q, a_addr;
	logic                t_last, j_last, i_last;
	logic                issue, adv;

	// pipeline between store read and mac
	logic                 valid_s1;
	tag_t                 tag_s1, tag_s0;
	logic [ELEM_BITS-1:0] a_rd_s1, b_rd_s1;

	logic                  mac_valid;
	tag_t                  mac_tag;
	logic [VALUE_BITS-1:0] mac_sum;

	// result register
	logic                  res_valid_q;
	logic [IDX_BITS-1:0]   res_row_q, res_col_q;
	logic [VALUE_BITS-1:0] res_value_q;
	logic                  res_last_q;

	// ------------------------------------------------------------ loading

	assign in_stall = (state_q != ST_LOAD);
	assign in_acc   = in_valid && !in_stall;

	assign a_size = CNT_W'(m_q * k_q);
	assign b_size = CNT_W'(k_q * n_q);

	assign a_wr     = in_acc && !op && (a_count_q < a_size);
	assign b_wr     = in_acc && op && (b_count_q < b_size);
	assign b_cnt_nx = CNT_W'(b_count_q + CNT_W'(b_wr));
	// the beat that fills B kicks off the product
	assign b_done   = in_acc && op && (b_cnt_nx >= b_size);

	assign cfg_hit = cfg_we && (cfg_index inside {REG_ROWS_A, REG_INNER_SIZE, REG_COLS_B});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= eff_dim(REG_BITS'(8), MAX_DIM);
			k_q <= eff_dim(REG_BITS'(8), MAX_DIM);
			n_q <= eff_dim(REG_BITS'(8), MAX_DIM);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS_A:     m_q <= eff_dim(cfg_data, MAX_DIM);
				REG_INNER_SIZE: k_q <= eff_dim(cfg_data, MAX_DIM);
				REG_COLS_B:     n_q <= eff_dim(cfg_data, MAX_DIM);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_count_q <= '0;
			b_count_q <= '0;
		end else if (cfg_hit || b_done) begin
			// register writes and a finished load both restart loading
			a_count_q <= '0;
			b_count_q <= '0;
		end else begin
			if (a_wr) begin
				a_count_q <= CNT_W'(a_count_q + CNT_W'(1));
			end
			b_count_q <= b_cnt_nx;
		end
	end

	// ------------------------------------------------------------ sequencer

	// whole pipeline moves only when the result register can take a beat
	assign adv   = !res_valid_q || !out_stall;
	assign issue = (state_q == ST_CALC) && adv;

	assign t_last = ({1'b0, t_q} == REG_BITS'(k_q - REG_BITS'(1)));
	assign j_last = ({1'b0, j_q} == REG_BITS'(n_q - REG_BITS'(1)));
	assign i_last = ({1'b0, i_q} == REG_BITS'(m_q - REG_BITS'(1)));

	// a element i*k+t, b element t*n+j
	assign a_addr = ADDR_W'(a_base_q + ADDR_W'(t_q));

	assign tag_s0.first  = (t_q == '0);
	assign tag_s0.last_t = t_last;
	assign tag_s0.row    = i_q;
	assign tag_s0.col    = j_q;
	assign tag_s0.last   = i_last && j_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			i_q      <= '0;
			j_q      <= '0;
			t_q      <= '0;
			a_base_q <= '0;
			b_addr_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (b_done) begin
						state_q  <= ST_CALC;
						i_q      <= '0;
						j_q      <= '0;
						t_q      <= '0;
						a_base_q <= '0;
						b_addr_q <= '0;
					end
				end
				ST_CALC: begin
					if (adv) begin
						if (!t_last) begin
							t_q      <= IDX_BITS'(t_q + IDX_BITS'(1));
							b_addr_q <= ADDR_W'(b_addr_q + ADDR_W'(n_q));
						end else begin
							t_q <= '0;
							if (!j_last) begin
								j_q      <= IDX_BITS'(j_q + IDX_BITS'(1));
								b_addr_q <= ADDR_W'(j_q + IDX_BITS'(1));
							end else begin
								j_q      <= '0;
								b_addr_q <= '0;
								i_q      <= IDX_BITS'(i_q + IDX_BITS'(1));
								a_base_q <= ADDR_W'(a_base_q + ADDR_W'(k_q));
								// last issue: loading reopens, tail drains
								if (i_last) begin
									state_q <= ST_LOAD;
								end
							end
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// ------------------------------------------------------------ stores

	mme_ram #(
		.WIDTH (ELEM_BITS),
		.DEPTH (STORE_DEPTH)
	) u_a_store (
		.clk   (clk),
		.we    (a_wr),
		.waddr (a_count_q[ADDR_W-1:0]),
		.wdata (elem_value),
		.re    (issue),
		.raddr (a_addr),
		.rdata (a_rd_s1)
	);

	mme_ram #(
		.WIDTH (ELEM_BITS),
		.DEPTH (STORE_DEPTH)
	) u_b_store (
		.clk   (clk),
		.we    (b_wr),
		.waddr (b_count_q[ADDR_W-1:0]),
		.wdata (elem_value),
		.re    (issue),
		.raddr (b_addr_q),
		.rdata (b_rd_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= (state_q == ST_CALC);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1 <= tag_s0;
		end
	end

	// ------------------------------------------------------------ mac

	mme_mac #(
		.ELEM_BITS (ELEM_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid_s1  (valid_s1),
		.tag_s1    (tag_s1),
		.a_s1      (a_rd_s1),
		.b_s1      (b_rd_s1),
		.res_valid (mac_valid),
		.res_tag   (mac_tag),
		.res_sum   (mac_sum)
	);

	// ------------------------------------------------------------ result register

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv && mac_valid) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && mac_valid) begin
			res_row_q   <= mac_tag.row;
			res_col_q   <= mac_tag.col;
			res_value_q <= mac_sum;
			res_last_q  <= mac_tag.last;
		end
	end

	assign out_valid = res_valid_q;
	assign out_row   = res_row_q;
	assign out_col   = res_col_q;
	assign out_value = res_value_q;
	assign out_last  = res_last_q;

endmodule

// ===== rtl/mme_checker.sv =====
// port-level checker of the matrix multiply engine, bound to the top level
`include "matrix_multiply_engine_defines.svh"

module mme_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           op,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [mme_pkg::IDX_BITS-1:0]   out_row,
	input logic [mme_pkg::IDX_BITS-1:0]   out_col,
	input logic [mme_pkg::VALUE_BITS-1:0] out_value,
	input logic                           out_last
);
	import mme_pkg::*;

	logic out_beat;

	assign out_beat = out_valid && !out_stall;

	// stalled result beat holds
	`MME_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_row) && $stable(out_col) && $stable(out_value) && $stable(out_last), "stalled result beat changed")

	// input closes only right after a beat of B
	`MME_ASSERT_NOW(a_stall_after_b, clk, arst_n, $rose(in_stall), $past(in_valid && !in_stall && op), "input stalled without a completing B beat")

	// back-to-back results walk row-major order
	`MME_ASSERT_NEXT(a_order, clk, arst_n, out_beat && !out_last, !out_valid || (out_row == $past(out_row) && out_col == IDX_BITS'($past(out_col) + 3'd1)) || (out_row == IDX_BITS'($past(out_row) + 3'd1) && out_col == '0), "result beats out of row-major order")

	// after the final beat a new matrix starts at the origin
	`MME_ASSERT_NEXT(a_restart, clk, arst_n, out_beat && out_last, !out_valid || (out_row == '0 && out_col == '0), "new product does not start at row 0, col 0")

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);
